>>> hw/rtl/subtractive_random_generator_core_assert.svh
// Assertion macros used by the subtractive generator back end RTL.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Checked on clk, held off while rst_n is low.
`define SRG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checked on every clk edge, reset included.
`define SRG_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define SRG_ASSERT(lbl, prop)
`define SRG_ASSERT_NORST(lbl, prop)
`endif
`endif

>>> hw/rtl/srg_pkg.sv
// Types, constants and arithmetic helpers of the subtractive generator.
package srg_pkg;

    localparam int unsigned TABLE_DEPTH = 55;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned VALUE_W     = 30;
    localparam int unsigned SEED_W      = 28;

    localparam logic [VALUE_W-1:0] MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0]  SEED_BASE = 28'd161803398;

    localparam logic [ADDR_W-1:0] TABLE_LAST      = 6'd55;
    localparam logic [ADDR_W-1:0] TABLE_LAST_ADDR = 6'd54;
    localparam logic [ADDR_W-1:0] FILL_STEP       = 6'd21;
    localparam logic [ADDR_W-1:0] LAG_START       = 6'd31;
    localparam logic [ADDR_W-1:0] LAG_BACK        = 6'd24;
    localparam logic [ADDR_W-1:0] WARM_OFFSET     = 6'd30;
    localparam logic [ADDR_W-1:0] IDX_ONE         = 6'd1;
    localparam logic [1:0]        WARM_LAST_PASS  = 2'd3;

    typedef struct packed {
        logic              reseed;
        logic [SEED_W-1:0] start;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WARM,
        ST_GEN_RD,
        ST_GEN_WR
    } state_t;

    // (a - b) mod 1e9, both operands below the modulus
    function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        sub_mod = (a >= b) ? (a - b) : (a - b + MODULUS);
    endfunction

    // next table position, wrapping 55 (or anything larger) back to 1
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
        advance = (idx >= TABLE_LAST) ? IDX_ONE : (idx + IDX_ONE);
    endfunction

endpackage

>>> hw/rtl/srg_if.sv
// Request and response channel interfaces.
interface srg_req_if import srg_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SEED_W-1:0] seed;

    modport source (output valid, output mode, output seed, input ready);
    modport sink   (input valid, input mode, input seed, output ready);
endinterface

interface srg_rsp_if import srg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/srg_ram.sv
// Generic RAM: one write port, two read ports with registered data.
module srg_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 55
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hw/rtl/srg_front.sv
// Front end: accepts request words, saturates the seed and flags reseeds.
module srg_front import srg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    srg_req_if.sink     req,
    input  logic        fifo_full,
    output logic        push,
    output cmd_t        cmd
);

    logic              seeded_reg;
    logic              seeded_next;
    logic [SEED_W-1:0] seed_sat;

    always_comb
    begin
        req.ready   = !fifo_full;
        push        = req.valid && !fifo_full;
        seed_sat    = (req.seed > SEED_BASE) ? SEED_BASE : req.seed;
        cmd.start   = SEED_BASE - seed_sat;
        // first word after reset always seeds
        cmd.reseed  = req.mode || !seeded_reg;
        seeded_next = seeded_reg || push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
        end
        else
        begin
            seeded_reg <= seeded_next;
        end
    end

endmodule

>>> hw/rtl/srg_cmd_fifo.sv
// Two-entry command queue between front and back end.
module srg_cmd_fifo import srg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd,
    input  logic pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_cmd    = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/srg_back.sv
// Back end: table seeding, warm-up and number generation over the lag RAM.
module srg_back import srg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    srg_rsp_if.source   rsp
);

`include "subtractive_random_generator_core_assert.svh"

    state_t             state_reg;
    state_t             state_next;
    logic [VALUE_W-1:0] prev_reg;
    logic [VALUE_W-1:0] prev_next;
    logic [VALUE_W-1:0] run_reg;
    logic [VALUE_W-1:0] run_next;
    logic [ADDR_W-1:0]  pos_reg;
    logic [ADDR_W-1:0]  pos_next;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0]  cnt_next;
    logic [ADDR_W-1:0]  widx_reg;
    logic [ADDR_W-1:0]  widx_next;
    logic [1:0]         pass_reg;
    logic [1:0]         pass_next;
    logic               wpend_reg;
    logic               wpend_next;
    logic [ADDR_W-1:0]  waddr_reg;
    logic [ADDR_W-1:0]  waddr_next;
    logic [ADDR_W-1:0]  r_idx_reg;
    logic [ADDR_W-1:0]  r_idx_next;
    logic [ADDR_W-1:0]  l_idx_reg;
    logic [ADDR_W-1:0]  l_idx_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [VALUE_W-1:0] rsp_value_reg;
    logic [VALUE_W-1:0] rsp_value_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr_a;
    logic [ADDR_W-1:0]  ram_raddr_b;
    logic [VALUE_W-1:0] ram_rdata_a;
    logic [VALUE_W-1:0] ram_rdata_b;
    logic [VALUE_W-1:0] diff;
    logic [ADDR_W:0]    pos_sum;
    logic               out_free;

    srg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        diff           = sub_mod(ram_rdata_a, ram_rdata_b);
        pos_sum        = {1'b0, pos_reg} + {1'b0, FILL_STEP};
        out_free       = !rsp_valid_reg || rsp.ready;

        state_next     = state_reg;
        prev_next      = prev_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        widx_next      = widx_reg;
        pass_next      = pass_reg;
        wpend_next     = 1'b0;
        waddr_next     = waddr_reg;
        r_idx_next     = r_idx_reg;
        l_idx_next     = l_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_value_next = rsp_value_reg;
        cmd_pop        = 1'b0;

        // warm-up writes land in the cycle after their reads
        ram_we         = wpend_reg;
        ram_waddr      = waddr_reg;
        ram_wdata      = diff;
        ram_raddr_a    = r_idx_reg - IDX_ONE;
        ram_raddr_b    = l_idx_reg - IDX_ONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.reseed)
                    begin
                        // position 55 takes the start value
                        ram_we     = 1'b1;
                        ram_waddr  = TABLE_LAST_ADDR;
                        ram_wdata  = {{(VALUE_W-SEED_W){1'b0}}, cmd.start};
                        prev_next  = {{(VALUE_W-SEED_W){1'b0}}, cmd.start};
                        run_next   = {{(VALUE_W-1){1'b0}}, 1'b1};
                        pos_next   = FILL_STEP;
                        cnt_next   = IDX_ONE;
                        r_idx_next = '0;
                        l_idx_next = LAG_START;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_GEN_RD;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg - IDX_ONE;
                ram_wdata = run_reg;
                run_next  = sub_mod(prev_reg, run_reg);
                prev_next = run_reg;
                pos_next  = (pos_sum >= {1'b0, TABLE_LAST}) ?
                            ADDR_W'(pos_sum - {1'b0, TABLE_LAST}) : pos_sum[ADDR_W-1:0];
                cnt_next  = cnt_reg + IDX_ONE;
                if (cnt_reg == TABLE_LAST_ADDR)
                begin
                    widx_next  = IDX_ONE;
                    pass_next  = '0;
                    state_next = ST_WARM;
                end
            end
            ST_WARM:
            begin
                ram_raddr_a = widx_reg - IDX_ONE;
                ram_raddr_b = (widx_reg <= LAG_BACK) ? (widx_reg + WARM_OFFSET) :
                              (widx_reg - LAG_BACK - IDX_ONE);
                wpend_next  = 1'b1;
                waddr_next  = widx_reg - IDX_ONE;
                widx_next   = advance(widx_reg);
                if (widx_reg == TABLE_LAST)
                begin
                    pass_next = pass_reg + 2'd1;
                    if (pass_reg == WARM_LAST_PASS)
                    begin
                        state_next = ST_GEN_RD;
                    end
                end
            end
            ST_GEN_RD:
            begin
                r_idx_next  = advance(r_idx_reg);
                l_idx_next  = advance(l_idx_reg);
                ram_raddr_a = advance(r_idx_reg) - IDX_ONE;
                ram_raddr_b = advance(l_idx_reg) - IDX_ONE;
                state_next  = ST_GEN_WR;
            end
            ST_GEN_WR:
            begin
                // addresses held, so read data stays put while stalled
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_idx_reg - IDX_ONE;
                    ram_wdata      = diff;
                    rsp_valid_next = 1'b1;
                    rsp_value_next = diff;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp.valid = rsp_valid_reg;
        rsp.value = rsp_value_reg;
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        run_reg       <= run_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        widx_reg      <= widx_next;
        pass_reg      <= pass_next;
        waddr_reg     <= waddr_next;
        rsp_value_reg <= rsp_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wpend_reg     <= 1'b0;
            r_idx_reg     <= '0;
            l_idx_reg     <= LAG_START;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpend_reg     <= wpend_next;
            r_idx_reg     <= r_idx_next;
            l_idx_reg     <= l_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `SRG_ASSERT(a_pop_only_idle, cmd_pop |-> state_reg == ST_IDLE)
    `SRG_ASSERT_NORST(a_idx_range, (r_idx_reg <= TABLE_LAST) && (l_idx_reg <= TABLE_LAST))
    `SRG_ASSERT(a_lag_distance, (l_idx_reg == r_idx_reg + LAG_START) || (l_idx_reg + LAG_BACK == r_idx_reg))
    `SRG_ASSERT(a_pend_in_warm, wpend_reg |-> (state_reg == ST_WARM || state_reg == ST_GEN_RD))
    `SRG_ASSERT(a_rsp_load, (state_reg == ST_GEN_WR && out_free) |=> (rsp_valid_reg && state_reg == ST_IDLE))

endmodule

>>> hw/rtl/subtractive_random_generator_core.sv
// A plain word passes the queue, the pop in idle, the lag table read, and the subtract
// and write into the output register; the back end takes no new word until that write.
// A reseed word (mode 1, or the first word after reset) first runs 54 fill
// writes plus 4 x 55 pipelined warm-up read/write steps on the same RAM.
// Reset (rst_n low, async): control, queue and indices clear; the table is not cleared
// and is always rewritten by the seeding pass before any read.
module subtractive_random_generator_core import srg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    srg_req_if.sink     req,
    srg_rsp_if.source   rsp
);

    // front -> queue
    logic push;
    cmd_t push_cmd;
    logic fifo_full;

    // queue -> back
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // Front end: takes request words, clamps the seed at 161803398 and
    // marks a word as a reseed when mode asks for it or nothing was seeded yet.
    srg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Short queue so the front keeps taking words during a long reseed.
    srg_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // Back end: owns the 55-word lag table, the seeding sequencer and the
    // output register, which lets a finished word wait for rsp.ready.
    srg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .rsp       (rsp)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the subtractive lagged random number generator core.
module testbench import srg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Request mode codes
    localparam logic MODE_NEXT   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    localparam int unsigned WARM_PASSES = 4;
    localparam int unsigned IDLE_PCT    = 14;
    localparam int unsigned RESEED_PCT  = 5;
    localparam int unsigned RANDOM_WORDS = 1532;
    localparam int unsigned DRAIN_GAP   = 20;

    // One pending request word plus its pacing hints.
    // calm: no idling on either side while this word is in play.
    // drain: hold the word back until every expected value is in.
    typedef struct {
        logic              mode;
        logic [SEED_W-1:0] seed;
        bit                calm;
        bit                drain;
    } req_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    srg_req_if req ();
    srg_rsp_if rsp ();

    subtractive_random_generator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    req_word_t          pending_words[$];
    logic [VALUE_W-1:0] expected_values[$];

    // Counters shared between driver and monitor are updated with NBAs so that
    // each side always reads the value from before the current edge.
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned total_words;
    int unsigned mismatch_count;
    bit          calm_phase;

    // ------------------------------------------------------------------
    // Generator prediction: own copy of the lag table and both indices.
    // Table positions run 1..55, matching the index registers directly.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] lag_words [1:TABLE_DEPTH];
    logic [ADDR_W-1:0]  draw_pos;
    logic [ADDR_W-1:0]  lag_pos;
    bit                 table_seeded;

    // (a - b) mod 1e9, computed in 32 bits so a + 1e9 cannot wrap
    function automatic logic [VALUE_W-1:0] mod_diff(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b);
        int unsigned wa;
        int unsigned wb;
        wa = a;
        wb = b;
        if (wa >= wb)
            return VALUE_W'(wa - wb);
        return VALUE_W'(wa + int'(MODULUS) - wb);
    endfunction

    // step a table position; 55 and anything above wrap back to 1
    function automatic logic [ADDR_W-1:0] bump_pos(input logic [ADDR_W-1:0] p);
        int unsigned n;
        n = p + 1;
        return (n > TABLE_LAST) ? IDX_ONE : ADDR_W'(n);
    endfunction

    function automatic void seed_lag_words(input logic [SEED_W-1:0] seed_in);
        logic [VALUE_W-1:0] prev;
        logic [VALUE_W-1:0] run;
        int unsigned        clamped;
        int unsigned        pos;
        int unsigned        other;
        int unsigned        i;
        int unsigned        k;
        // seed above range saturates, so the start value never goes negative
        clamped = (seed_in > SEED_BASE) ? SEED_BASE : seed_in;
        prev = VALUE_W'(int'(SEED_BASE) - clamped);
        run = 1;
        lag_words[TABLE_DEPTH] = prev;
        // fill in strides of 21 with the running difference chain
        for (i = 1; i < TABLE_DEPTH; i++)
        begin
            pos = (FILL_STEP * i) % TABLE_DEPTH;
            lag_words[pos] = run;
            run = mod_diff(prev, run);
            prev = lag_words[pos];
        end
        // warm-up: four passes of lag-31 subtraction
        for (k = 0; k < WARM_PASSES; k++)
        begin
            for (i = 1; i <= TABLE_DEPTH; i++)
            begin
                other = 1 + (i + WARM_OFFSET) % TABLE_DEPTH;
                lag_words[i] = mod_diff(lag_words[i], lag_words[other]);
            end
        end
        draw_pos = '0;
        lag_pos = LAG_START;
        table_seeded = 1'b1;
    endfunction

    // next value for one accepted request; reseeds on mode 1 or the first word
    function automatic logic [VALUE_W-1:0] draw_value(input logic mode_in,
                                                      input logic [SEED_W-1:0] seed_in);
        logic [VALUE_W-1:0] v;
        if (mode_in == MODE_RESEED || !table_seeded)
            seed_lag_words(seed_in);
        draw_pos = bump_pos(draw_pos);
        lag_pos = bump_pos(lag_pos);
        v = mod_diff(lag_words[draw_pos] % MODULUS, lag_words[lag_pos] % MODULUS);
        lag_words[draw_pos] = v;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic add_word(input logic mode_in, input logic [SEED_W-1:0] seed_in,
                            input bit calm_in, input bit drain_in);
        req_word_t w;
        w.mode = mode_in;
        w.seed = seed_in;
        w.calm = calm_in;
        w.drain = drain_in;
        pending_words.push_back(w);
    endtask

    // mostly in-range seeds, some at the edges, some anywhere in the 28-bit field
    function automatic logic [SEED_W-1:0] pick_seed();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return SEED_W'($urandom_range(int'(SEED_BASE), 0));
        if (roll < 75)
            return '0;
        if (roll < 80)
            return SEED_BASE;
        return SEED_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents words from pending_words, holds valid until accepted,
    // predicts the result at acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        req_word_t   nxt;
        int unsigned outstanding;
        bit          accepted;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= MODE_NEXT;
            req.seed <= '0;
            words_sent <= 0;
            calm_phase <= 1'b0;
        end
        else
        begin
            accepted = req.valid && req.ready;
            if (accepted)
            begin
                expected_values.push_back(draw_value(req.mode, req.seed));
                words_sent <= words_sent + 1;
            end
            // channel free after this edge: load the next word or idle
            if (!req.valid || req.ready)
            begin
                outstanding = words_sent + (accepted ? 1 : 0) - words_checked;
                if (pending_words.size() != 0
                    && !(pending_words[0].drain && outstanding != 0)
                    && (pending_words[0].calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_words.pop_front();
                    req.valid <= 1'b1;
                    req.mode <= nxt.mode;
                    req.seed <= nxt.seed;
                    calm_phase <= nxt.calm;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, compares each value with the oldest
    // prediction. Only predictions queued before this edge are eligible.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [VALUE_W-1:0] want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            words_checked <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (words_checked >= words_sent)
                begin
                    report_mismatch($sformatf("value %0d with no request outstanding",
                                              rsp.value));
                end
                else
                begin
                    want = expected_values.pop_front();
                    words_checked <= words_checked + 1;
                    if (rsp.value !== want)
                        report_mismatch($sformatf("word %0d: value %0d, predicted %0d",
                                                  words_checked, rsp.value, want));
                end
            end
            rsp.ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n;
        logic        m;
        mismatch_count = 0;
        table_seeded = 1'b0;
        draw_pos = '0;
        lag_pos = LAG_START;
        foreach (lag_words[i])
            lag_words[i] = '0;

        // directed: first word seeds even with mode 0, seed edges, saturation
        add_word(MODE_NEXT, 28'd12345, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'hFFFFFFF, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'd0, 1'b0, 1'b0);
        add_word(MODE_RESEED, 28'd0, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'd7, 1'b0, 1'b0);
        // start value exactly zero
        add_word(MODE_RESEED, SEED_BASE, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'd0, 1'b0, 1'b0);
        // just above range and top of field: both saturate
        add_word(MODE_RESEED, SEED_BASE + 28'd1, 1'b0, 1'b0);
        add_word(MODE_RESEED, 28'hFFFFFFF, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'hFFFFFFF, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'h5555555, 1'b0, 1'b0);
        add_word(MODE_RESEED, 28'h5555555, 1'b0, 1'b0);
        add_word(MODE_RESEED, 28'hAAAAAAA, 1'b0, 1'b0);
        add_word(MODE_RESEED, 28'd1, 1'b0, 1'b0);
        // sender holds off until everything has drained
        add_word(MODE_NEXT, 28'd0, 1'b0, 1'b1);
        add_word(MODE_RESEED, SEED_BASE - 28'd1, 1'b0, 1'b0);
        add_word(MODE_NEXT, 28'd3, 1'b1, 1'b0);
        add_word(MODE_NEXT, 28'd0, 1'b1, 1'b0);

        // random: long runs of draws (indices wrap many times), rare reseeds;
        // words 500..799 run with no idling on either side
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            m = ($urandom_range(99) < RESEED_PCT) ? MODE_RESEED : MODE_NEXT;
            add_word(m, pick_seed(), (n >= 500 && n < 800),
                     (n % 300) == (300 - DRAIN_GAP));
        end
        total_words = pending_words.size();

        // async reset: negedge at time 0, released on a rising clock edge
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // words_sent/words_checked move by NBA, so these reads are edge-stable
        while (words_sent != total_words)
            @(posedge clk);
        while (words_checked != words_sent)
            @(posedge clk);
        // room for a stray extra value to show up
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: about 6x the slowest expected run
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
